// ----- hdl/utf8cf_pkg.sv -----
package utf8cf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned CpW    = 21;
  localparam int unsigned MaxSeq = 4;
  localparam int unsigned IdxW   = $clog2(MaxSeq);

  localparam logic [CpW-1:0] PrivLo   = 21'h00EE00;
  localparam logic [CpW-1:0] PrivHi   = 21'h00EE0F;
  localparam logic [CpW-1:0] CtrlLim  = 21'h000020;
  localparam logic [CpW-1:0] CpDel    = 21'h00007F;
  localparam logic [CpW-1:0] CpTab    = 21'h000009;
  localparam logic [CpW-1:0] CpLf     = 21'h00000A;
  localparam logic [CpW-1:0] CpCr     = 21'h00000D;
  localparam logic [CpW-1:0] Max1Byte = 21'h00007F;
  localparam logic [CpW-1:0] Max2Byte = 21'h0007FF;
  localparam logic [CpW-1:0] Max3Byte = 21'h00FFFF;
  localparam logic [ByteW-1:0] Space  = 8'h20;
  localparam logic [CountW-1:0] CountSat = 16'hFFFF;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             has_byte;
    logic             end_of_run;
    logic             end_of_string;
  } out_beat_t;

  typedef struct packed {
    logic [MaxSeq-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]              last_idx;
    logic                         has_byte;
    logic                         eos;
  } group_t;

endpackage

// ----- hdl/utf8_control_char_filter.sv -----
// Sanitizes a UTF-8 string one byte per beat: it decodes 1 to 4 byte sequences, drops
// U+EE00..U+EE0F and control characters (tab, LF and CR turn into a space), re-encodes
// the rest in shortest form, and stops output once the configured character limit is
// reached or on malformed input until the last byte of the string. Each input beat is
// registered, decoded combinationally and its re-encoded bytes are loaded into a group register,
// which sends them one output beat per cycle while out_ready_i is high; an input beat waits in
// the input register until the group register is free. A last input beat that yields no byte
// produces one end marker beat with has_byte low. Write the character limit only while the
// block is idle.
module utf8_control_char_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utf8cf_pkg::CountW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  utf8cf_pkg::in_beat_t          in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output utf8cf_pkg::out_beat_t         out_beat_o
);
  import utf8cf_pkg::*;

  logic [CountW-1:0] char_limit_q;
  in_beat_t          inq_q;
  logic              inq_valid_q;
  logic              grp_free;
  logic              take;
  logic              produce;
  group_t            group;

  assign cfg_ready_o = 1'b1;
  assign take        = inq_valid_q && grp_free;
  assign in_ready_o  = !inq_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_limit_q <= '0;
      inq_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        char_limit_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        inq_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_q <= in_beat_i;
    end
  end

  utf8cf_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .beat_i       (inq_q),
    .char_limit_i (char_limit_q),
    .produce_o    (produce),
    .group_o      (group)
  );

  utf8cf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && produce),
    .group_i     (group),
    .free_o      (grp_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ----- hdl/utf8cf_decoder.sv -----
module utf8cf_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  utf8cf_pkg::in_beat_t       beat_i,
  input  logic [utf8cf_pkg::CountW-1:0] char_limit_i,
  output logic                       produce_o,
  output utf8cf_pkg::group_t         group_o
);
  import utf8cf_pkg::*;

  logic [CpW-1:0]    pcp_q, pcp_d;
  logic [1:0]        pend_q, pend_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              halt_q, halt_d;

  logic              complete;
  logic [CpW-1:0]    cp;
  logic [ByteW-1:0]  b;
  logic              limit_on;
  logic              kept;
  logic [2:0]        n;
  logic [CountW-1:0] cnt_inc;
  logic [CpW-1:0]    cont_cp;

  assign b        = beat_i.data_byte;
  assign limit_on = (char_limit_i != '0);
  assign cont_cp  = {pcp_q[CpW-7:0], b[5:0]};

  always_comb begin
    pcp_d    = pcp_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    halt_d   = halt_q;
    complete = 1'b0;
    cp       = '0;
    kept     = 1'b0;
    n        = 3'd0;
    cnt_inc  = cnt_q;
    group_o  = '0;

    if (!halt_q) begin
      if (pend_q == 2'd0) begin
        if (limit_on && cnt_q >= char_limit_i) begin
          halt_d = 1'b1;
          pend_d = 2'd0;
          pcp_d  = '0;
        end else if (b[7] == 1'b0) begin
          cp       = {{(CpW-ByteW){1'b0}}, b};
          complete = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          pcp_d  = {{(CpW-5){1'b0}}, b[4:0]};
          pend_d = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          pcp_d  = {{(CpW-4){1'b0}}, b[3:0]};
          pend_d = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          pcp_d  = {{(CpW-3){1'b0}}, b[2:0]};
          pend_d = 2'd3;
        end else begin
          halt_d = 1'b1;
          pend_d = 2'd0;
          pcp_d  = '0;
        end
      end else if (b[7:6] != 2'b10) begin
        halt_d = 1'b1;
        pend_d = 2'd0;
        pcp_d  = '0;
      end else begin
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          cp       = cont_cp;
          pcp_d    = '0;
          complete = 1'b1;
        end else begin
          pcp_d = cont_cp;
        end
      end
    end

    if (complete && !(cp >= PrivLo && cp <= PrivHi)) begin
      if (cp < CtrlLim || cp == CpDel) begin
        if (cp == CpTab || cp == CpLf || cp == CpCr) begin
          kept              = 1'b1;
          n                 = 3'd1;
          group_o.bytes[0]  = Space;
        end
      end else begin
        kept = 1'b1;
        if (cp <= Max1Byte) begin
          n                = 3'd1;
          group_o.bytes[0] = cp[7:0];
        end else if (cp <= Max2Byte) begin
          n                = 3'd2;
          group_o.bytes[0] = {3'b110, cp[10:6]};
          group_o.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= Max3Byte) begin
          n                = 3'd3;
          group_o.bytes[0] = {4'b1110, cp[15:12]};
          group_o.bytes[1] = {2'b10, cp[11:6]};
          group_o.bytes[2] = {2'b10, cp[5:0]};
        end else begin
          n                = 3'd4;
          group_o.bytes[0] = {5'b11110, cp[20:18]};
          group_o.bytes[1] = {2'b10, cp[17:12]};
          group_o.bytes[2] = {2'b10, cp[11:6]};
          group_o.bytes[3] = {2'b10, cp[5:0]};
        end
      end
    end

    if (kept) begin
      if (cnt_q != CountSat) begin
        cnt_inc = cnt_q + 1'b1;
      end
      cnt_d = cnt_inc;
      if (limit_on && cnt_inc >= char_limit_i) begin
        halt_d = 1'b1;
        pend_d = 2'd0;
        pcp_d  = '0;
      end
    end

    group_o.has_byte = (n != 3'd0);
    group_o.last_idx = (n != 3'd0) ? IdxW'(n - 3'd1) : '0;
    group_o.eos      = beat_i.last;

    if (beat_i.last) begin
      pcp_d  = '0;
      pend_d = 2'd0;
      cnt_d  = '0;
      halt_d = 1'b0;
    end
  end

  assign produce_o = (n != 3'd0) || beat_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q  <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
      halt_q <= 1'b0;
    end else if (take_i) begin
      pcp_q  <= pcp_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      halt_q <= halt_d;
    end
  end

endmodule

// ----- hdl/utf8cf_serializer.sv -----
module utf8cf_serializer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  utf8cf_pkg::group_t    group_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8cf_pkg::out_beat_t out_beat_o
);
  import utf8cf_pkg::*;

  group_t          grp_q;
  logic            grp_valid_q, grp_valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            final_beat;
  logic            pop;

  assign final_beat  = (idx_q == grp_q.last_idx);
  assign pop         = grp_valid_q && out_ready_i;
  assign free_o      = !grp_valid_q || (pop && final_beat);
  assign out_valid_o = grp_valid_q;

  always_comb begin
    out_beat_o.out_byte      = grp_q.has_byte ? grp_q.bytes[idx_q] : '0;
    out_beat_o.has_byte      = grp_q.has_byte;
    out_beat_o.end_of_run    = final_beat;
    out_beat_o.end_of_string = final_beat && grp_q.eos;
  end

  always_comb begin
    grp_valid_d = grp_valid_q;
    idx_d       = idx_q;
    if (pop) begin
      if (final_beat) begin
        grp_valid_d = 1'b0;
        idx_d       = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (load_i) begin
      grp_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      grp_valid_q <= grp_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= group_i;
    end
  end

endmodule

// ----- dv/tb_utf8_control_char_filter.sv -----
`timescale 1ns / 100ps

module tb_utf8_control_char_filter;
  import utf8cf_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseBeats = 30;
  localparam int unsigned TailChars  = 15;

  localparam logic [20:0] PrivFirst = 21'h00EE00;
  localparam logic [20:0] PrivLast  = 21'h00EE0F;
  localparam logic [20:0] CtrlEnd   = 21'h000020;
  localparam logic [20:0] CpDel     = 21'h00007F;
  localparam logic [20:0] CpTab     = 21'h000009;
  localparam logic [20:0] CpLf      = 21'h00000A;
  localparam logic [20:0] CpCr      = 21'h00000D;
  localparam logic [7:0]  Space8    = 8'h20;
  localparam logic [15:0] CountTop  = 16'hFFFF;

  localparam out_beat_t EndMark = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam out_beat_t Blank   = '{8'h00, 1'b0, 1'b0, 1'b0};

  typedef struct {
    in_beat_t  stim;
    bit        typed;
    out_beat_t want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [15:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_beat_t             in_beat_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_beat_t            out_beat_o;

  logic [15:0] lim_r     = '0;
  logic [20:0] acc_cp    = '0;
  logic [1:0]  cont_left = '0;
  logic [15:0] kept_cnt  = '0;
  logic        muted     = 1'b0;

  out_beat_t expected_q[$];
  in_beat_t  plan_q[$];
  int        errors    = 0;
  int        cycle_cnt = 0;
  bit        calm      = 1'b0;
  bit        hold_now  = 1'b0;

  row_t opening [25] = '{
    '{'{8'h41, 1'b0}, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b0}},
    '{'{8'h09, 1'b0}, 1'b1, '{8'h20, 1'b1, 1'b1, 1'b0}},
    '{'{8'h0A, 1'b0}, 1'b1, '{8'h20, 1'b1, 1'b1, 1'b0}},
    '{'{8'h0D, 1'b0}, 1'b1, '{8'h20, 1'b1, 1'b1, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, Blank},
    '{'{8'h7F, 1'b0}, 1'b0, Blank},
    '{'{8'hC0, 1'b0}, 1'b0, Blank},
    '{'{8'h80, 1'b0}, 1'b0, Blank},
    '{'{8'hEE, 1'b0}, 1'b0, Blank},
    '{'{8'hB8, 1'b0}, 1'b0, Blank},
    '{'{8'h80, 1'b0}, 1'b0, Blank},
    '{'{8'hF7, 1'b0}, 1'b0, Blank},
    '{'{8'hBF, 1'b0}, 1'b0, Blank},
    '{'{8'hBF, 1'b0}, 1'b0, Blank},
    '{'{8'hBF, 1'b0}, 1'b0, Blank},
    '{'{8'hE2, 1'b0}, 1'b0, Blank},
    '{'{8'h82, 1'b1}, 1'b1, EndMark},
    '{'{8'hC2, 1'b0}, 1'b0, Blank},
    '{'{8'h41, 1'b0}, 1'b0, Blank},
    '{'{8'hFF, 1'b1}, 1'b1, EndMark},
    '{'{8'h80, 1'b1}, 1'b1, EndMark},
    '{'{8'hF8, 1'b0}, 1'b0, Blank},
    '{'{8'h7E, 1'b1}, 1'b1, EndMark},
    '{'{8'h00, 1'b1}, 1'b1, EndMark},
    '{'{8'h7E, 1'b1}, 1'b1, '{8'h7E, 1'b1, 1'b1, 1'b1}}
  };

  utf8_control_char_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always #10ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_utf8_control_char_filter: errors");
      $finish;
    end
  end

  function automatic int utf8_len(input logic [20:0] cp);
    if (cp <= 21'h7F) return 1;
    if (cp <= 21'h7FF) return 2;
    if (cp <= 21'hFFFF) return 3;
    return 4;
  endfunction

  // Byte 0 is sent first. A length above the shortest gives an overlong form.
  function automatic logic [3:0][7:0] utf8_pack(input logic [20:0] cp, input int len);
    logic [3:0][7:0] enc;
    enc = '0;
    case (len)
      1: enc[0] = cp[7:0];
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    return enc;
  endfunction

  function automatic void halt_string();
    muted     = 1'b1;
    cont_left = '0;
    acc_cp    = '0;
  endfunction

  function automatic int filter_byte(input in_beat_t b, output out_beat_t [3:0] res);
    logic [7:0]      d;
    logic [20:0]     cp;
    logic [3:0][7:0] enc;
    logic            done;
    int              n;
    d    = b.data_byte;
    cp   = '0;
    enc  = '0;
    done = 1'b0;
    n    = 0;
    res  = '0;
    if (!muted) begin
      if (cont_left == 2'd0) begin
        if (lim_r != 0 && kept_cnt >= lim_r) begin
          halt_string();
        end else if (d[7] == 1'b0) begin
          cp   = {13'd0, d};
          done = 1'b1;
        end else if (d[7:5] == 3'b110) begin
          acc_cp    = {16'd0, d[4:0]};
          cont_left = 2'd1;
        end else if (d[7:4] == 4'b1110) begin
          acc_cp    = {17'd0, d[3:0]};
          cont_left = 2'd2;
        end else if (d[7:3] == 5'b11110) begin
          acc_cp    = {18'd0, d[2:0]};
          cont_left = 2'd3;
        end else begin
          halt_string();
        end
      end else if (d[7:6] != 2'b10) begin
        halt_string();
      end else begin
        acc_cp    = {acc_cp[14:0], d[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          cp     = acc_cp;
          acc_cp = '0;
          done   = 1'b1;
        end
      end
    end
    if (done && !(cp >= PrivFirst && cp <= PrivLast)) begin
      if (cp < CtrlEnd || cp == CpDel) begin
        if (cp == CpTab || cp == CpLf || cp == CpCr) begin
          enc[0] = Space8;
          n      = 1;
        end
      end else begin
        n   = utf8_len(cp);
        enc = utf8_pack(cp, n);
      end
      if (n > 0) begin
        if (kept_cnt != CountTop) kept_cnt++;
        if (lim_r != 0 && kept_cnt >= lim_r) halt_string();
      end
    end
    for (int k = 0; k < n; k++) begin
      res[k] = '{enc[k], 1'b1, k == n - 1, b.last && k == n - 1};
    end
    if (b.last) begin
      if (n == 0) begin
        res[0] = EndMark;
        n      = 1;
      end
      acc_cp    = '0;
      cont_left = '0;
      kept_cnt  = '0;
      muted     = 1'b0;
    end
    return n;
  endfunction

  function automatic void check_beat(input out_beat_t got);
    out_beat_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 100) begin
        $display("%0t: expected no beat, got byte=%h has=%b run=%b eos=%b", $time,
                 got.out_byte, got.has_byte, got.end_of_run, got.end_of_string);
      end
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 100) begin
          $display("%0t: expected byte=%h has=%b run=%b eos=%b, got byte=%h has=%b run=%b eos=%b",
                   $time, want.out_byte, want.has_byte, want.end_of_run, want.end_of_string,
                   got.out_byte, got.has_byte, got.end_of_run, got.end_of_string);
        end
      end
    end
  endfunction

  task automatic send_byte(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t [3:0] res;
    int              n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n = filter_byte(b, res);
    if (typed) begin
      expected_q.insert(expected_q.size(), want);
    end else begin
      for (int k = 0; k < n; k++) expected_q.insert(expected_q.size(), res[k]);
    end
  endtask

  task automatic set_limit(input logic [15:0] v);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lim_r = v;
  endtask

  // Mostly well-formed characters, with overlong forms, stray bytes, broken
  // continuations and cut-off sequences mixed in.
  task automatic plan_string(input int nchars);
    logic [7:0]      seq[$];
    logic [20:0]     cp;
    logic [3:0][7:0] enc;
    logic [7:0]      junk;
    int              pick;
    int              len;
    int              keep;
    for (int c = 0; c < nchars; c++) begin
      pick = $urandom_range(0, 99);
      cp   = '0;
      len  = 1;
      if (pick < 30) begin
        cp = 21'($urandom_range(32'h20, 32'h7E));
      end else if (pick < 38) begin
        case ($urandom_range(0, 4))
          0: cp = CpTab;
          1: cp = CpLf;
          2: cp = CpCr;
          3: cp = CpDel;
          default: cp = 21'($urandom_range(0, 31));
        endcase
      end else if (pick < 53) begin
        cp  = 21'($urandom_range(32'h80, 32'h7FF));
        len = 2;
      end else if (pick < 65) begin
        cp  = 21'($urandom_range(32'h800, 32'hFFFF));
        len = 3;
      end else if (pick < 72) begin
        cp  = 21'($urandom_range(32'hEDFE, 32'hEE11));
        len = 3;
      end else if (pick < 81) begin
        cp  = 21'($urandom_range(32'h10000, 32'h1FFFFF));
        len = 4;
      end else if (pick < 87) begin
        cp  = 21'($urandom_range(0, 32'h7FF));
        len = $urandom_range(utf8_len(cp) + 1, 4);
      end else if (pick >= 92) begin
        cp  = 21'($urandom_range(32'h80, 32'h1FFFFF));
        len = utf8_len(cp);
      end
      keep = len;
      if (pick >= 92) keep = $urandom_range(1, len - 1);
      enc = utf8_pack(cp, len);
      if (pick >= 87 && pick < 92) begin
        seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end else begin
        for (int k = 0; k < keep; k++) seq.insert(seq.size(), enc[k]);
      end
      if (pick >= 92 && pick < 96) begin
        junk = 8'($urandom_range(0, 255));
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        seq.insert(seq.size(), junk);
      end
    end
    foreach (seq[k]) begin
      plan_q.insert(plan_q.size(), in_beat_t'{seq[k], k == seq.size() - 1});
    end
  endtask

  initial begin : drain
    int stall;
    stall       = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_beat(out_beat_o);
      if (hold_now) begin
        hold_now = 1'b0;
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else begin
        if (stall == 0 && !calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 16);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          stall--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] limits [6];
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_beat_i   = '0;
    limits = '{16'd2, 16'd0, 16'd1, 16'd0, 16'd3, 16'($urandom_range(4, 8))};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i].stim, opening[i].typed, opening[i].want);

    // Phases end wherever the byte count says, often inside a string.
    foreach (limits[p]) begin
      set_limit(limits[p]);
      for (int s = 0; s < PhaseBeats; s++) begin
        if (plan_q.size() == 0) begin
          plan_string(($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(1, 5));
        end
        if (p == 1 && s == 20) hold_now = 1'b1;
        send_byte(plan_q.pop_front(), 1'b0, Blank);
      end
    end

    // The last stretch runs without idling under the top limit.
    calm = 1'b1;
    set_limit(CountTop);
    while (plan_q.size() != 0) send_byte(plan_q.pop_front(), 1'b0, Blank);
    for (int i = 0; i <= TailChars; i++) begin
      send_byte('{8'($urandom_range(32'h20, 32'h7E)), i == TailChars}, 1'b0, Blank);
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_utf8_control_char_filter: clean");
    end else begin
      $display("tb_utf8_control_char_filter: errors");
    end
    $finish;
  end

endmodule
